// File: sv/ptrf_pkg.sv
package ptrf_pkg;

   localparam int TIME_BITS      = 32;
   localparam int RPM_BITS       = 20;
   localparam int MUL_BITS       = 7;
   localparam int STRENGTH_BITS  = 4;
   localparam int TIMEOUT_BITS   = 24;
   localparam int COUNT_BITS     = 8;
   localparam int NUM_BITS       = 34;
   localparam int WSUM_BITS      = RPM_BITS + 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [RPM_BITS-1:0]      RPM_MAX        = '1;
   localparam logic [26:0]              RPM_Q4_SCALE   = 27'd96000000;
   localparam logic [RPM_BITS-1:0]      DECEL_FLOOR_Q4 = RPM_BITS'(160);
   localparam logic [STRENGTH_BITS-1:0] STRENGTH_FULL  = 4'd10;
   localparam logic [WSUM_BITS-1:0]     EMA_ROUND      = WSUM_BITS'(5);
   localparam logic [COUNT_BITS-1:0]    COUNT_MAX      = 8'd255;

   localparam logic [MUL_BITS-1:0]      PPR_RESET      = 7'd1;
   localparam logic [MUL_BITS-1:0]      RATIO_RESET    = 7'd10;
   localparam logic [STRENGTH_BITS-1:0] STRENGTH_RESET = 4'd3;
   localparam logic [TIMEOUT_BITS-1:0]  TIMEOUT_RESET  = 24'd500000;

   typedef enum logic {
      OP_PULSE = 1'b0,
      OP_EVAL  = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PPR      = 2'd0,
      CSR_RATIO    = 2'd1,
      CSR_STRENGTH = 2'd2,
      CSR_TIMEOUT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      op_type                op;
      logic [TIME_BITS-1:0]  time_us;
   } req_word_type;

   typedef struct packed {
      logic [RPM_BITS-1:0]   rpm_q4;
      logic                  updated;
      logic                  timed_out;
      logic                  saturated;
   } rsp_word_type;

endpackage

// File: sv/pulse_tachometer_rpm_filter.sv
// Channel   Direction  Handshake            Word
// req       in         req_valid/req_stall  req_word_type: op, time_us
// rsp       out        rsp_valid/rsp_stall  rsp_word_type: rpm_q4, updated, timed_out, saturated
// csr       in         csr_we               csr_index, csr_wdata
//
// A pulse passes through S_PULSE and S_FINISH before its result is registered.
// An evaluate with pulses to average uses one restoring divider that retires
// one quotient bit per cycle and one shift-add multiplier that retires one
// multiplier bit per cycle.
// Reset is synchronous and brings back the register defaults and zero speed.
// A new word is taken while the previous result waits in the output register.
module pulse_tachometer_rpm_filter #(
   parameter int SUM_BITS = 40
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  ptrf_pkg::req_word_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output ptrf_pkg::rsp_word_type                 rsp_data,
   input  logic                                   csr_we,
   input  logic [ptrf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ptrf_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import ptrf_pkg::*;

   localparam int QW  = (SUM_BITS > NUM_BITS) ? SUM_BITS : NUM_BITS;
   localparam int DVW = SUM_BITS + MUL_BITS;
   localparam int CW  = $clog2(QW + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_PULSE,
      S_EVAL,
      S_DIV_AVG,
      S_MUL_DEN,
      S_MUL_NUM,
      S_DIV_RPM,
      S_SMOOTH,
      S_DIV_EMA,
      S_FINISH
   } state_type;

   state_type                 state_ff;
   logic [TIME_BITS-1:0]      time_ff;
   logic [TIME_BITS-1:0]      prev_ff;
   logic                      seen_ff;
   logic [SUM_BITS-1:0]       sum_ff;
   logic [COUNT_BITS-1:0]     cnt_ff;
   logic [RPM_BITS-1:0]       shown_ff;
   logic [RPM_BITS-1:0]       smooth_ff;
   logic [RPM_BITS-1:0]       fresh_ff;
   logic                      upd_ff;
   logic                      tmo_ff;
   logic                      sat_ff;
   logic [QW-1:0]             quo_ff;
   logic [DVW-1:0]            rem_ff;
   logic [DVW-1:0]            dvs_ff;
   logic [CW-1:0]             step_ff;
   logic [DVW-1:0]            mcand_ff;
   logic [MUL_BITS-1:0]       mplier_ff;
   logic [DVW-1:0]            acc_ff;
   logic [MUL_BITS-1:0]       ppr_ff;
   logic [MUL_BITS-1:0]       ratio_ff;
   logic [STRENGTH_BITS-1:0]  strength_ff;
   logic [TIMEOUT_BITS-1:0]   timeout_ff;
   logic                      rsp_valid_ff;
   rsp_word_type              rsp_data_ff;

   logic [DVW:0]              trial_in;
   logic [DVW:0]              diff_in;
   logic                      take_in;
   logic [DVW-1:0]            rem_in;
   logic [QW-1:0]             quo_in;
   logic [DVW-1:0]            acc_in;
   logic [TIME_BITS-1:0]      age_in;
   logic [SUM_BITS:0]         sum_in;
   logic                      late_in;
   logic [STRENGTH_BITS-1:0]  s_in;
   logic                      rapid_in;
   logic [WSUM_BITS-1:0]      wsum_in;
   logic                      last_in;

   // restoring divider, one quotient bit per cycle
   assign trial_in = {rem_ff, quo_ff[QW-1]};
   assign diff_in  = trial_in - {1'b0, dvs_ff};
   assign take_in  = !diff_in[DVW];
   assign rem_in   = take_in ? diff_in[DVW-1:0] : trial_in[DVW-1:0];
   assign quo_in   = {quo_ff[QW-2:0], take_in};

   // shift-add multiplier, one multiplier bit per cycle
   assign acc_in   = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;

   assign last_in  = (step_ff == CW'(1));
   assign age_in   = time_ff - prev_ff;
   assign sum_in   = {1'b0, sum_ff} + (SUM_BITS + 1)'(age_in);
   assign late_in  = !seen_ff || (age_in > TIME_BITS'(timeout_ff));
   assign s_in     = (strength_ff > STRENGTH_FULL) ? STRENGTH_FULL : strength_ff;
   assign rapid_in = (shown_ff > DECEL_FLOOR_Q4) &&
                     ((WSUM_BITS'(fresh_ff) * WSUM_BITS'(10)) <
                      (WSUM_BITS'(shown_ff) * WSUM_BITS'(7)));
   assign wsum_in  = WSUM_BITS'(smooth_ff) * WSUM_BITS'(s_in) +
                     WSUM_BITS'(fresh_ff) * WSUM_BITS'(STRENGTH_FULL - s_in) + EMA_ROUND;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ff      <= '0;
         seen_ff      <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         shown_ff     <= '0;
         smooth_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         ppr_ff       <= PPR_RESET;
         ratio_ff     <= RATIO_RESET;
         strength_ff  <= STRENGTH_RESET;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PPR:      ppr_ff      <= csr_wdata[MUL_BITS-1:0];
               CSR_RATIO:    ratio_ff    <= csr_wdata[MUL_BITS-1:0];
               CSR_STRENGTH: strength_ff <= csr_wdata[STRENGTH_BITS-1:0];
               CSR_TIMEOUT:  timeout_ff  <= csr_wdata[TIMEOUT_BITS-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  time_ff  <= req_data.time_us;
                  upd_ff   <= 1'b0;
                  tmo_ff   <= 1'b0;
                  sat_ff   <= 1'b0;
                  state_ff <= (req_data.op == OP_EVAL) ? S_EVAL : S_PULSE;
               end
            end
            S_PULSE: begin
               if (seen_ff) begin
                  sum_ff <= sum_in[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_in[SUM_BITS-1:0];
                  if (cnt_ff != COUNT_MAX) begin
                     cnt_ff <= cnt_ff + COUNT_BITS'(1);
                  end
               end
               prev_ff  <= time_ff;
               seen_ff  <= 1'b1;
               state_ff <= S_FINISH;
            end
            S_EVAL: begin
               if (late_in) begin
                  shown_ff  <= '0;
                  smooth_ff <= '0;
                  sum_ff    <= '0;
                  cnt_ff    <= '0;
                  tmo_ff    <= 1'b1;
                  state_ff  <= S_FINISH;
               end else if (cnt_ff == '0) begin
                  state_ff  <= S_FINISH;
               end else begin
                  quo_ff    <= QW'(sum_ff) << (QW - SUM_BITS);
                  rem_ff    <= '0;
                  dvs_ff    <= DVW'(cnt_ff);
                  step_ff   <= CW'(SUM_BITS);
                  sum_ff    <= '0;
                  cnt_ff    <= '0;
                  state_ff  <= S_DIV_AVG;
               end
            end
            S_DIV_AVG: begin
               quo_ff  <= quo_in;
               rem_ff  <= rem_in;
               if (last_in) begin
                  if (quo_in == '0) begin
                     state_ff <= S_FINISH;
                  end else begin
                     mcand_ff  <= DVW'(quo_in[SUM_BITS-1:0]);
                     mplier_ff <= (ppr_ff == '0) ? MUL_BITS'(1) : ppr_ff;
                     acc_ff    <= '0;
                     step_ff   <= CW'(MUL_BITS);
                     state_ff  <= S_MUL_DEN;
                  end
               end else begin
                  step_ff <= step_ff - CW'(1);
               end
            end
            S_MUL_DEN: begin
               if (last_in) begin
                  dvs_ff    <= acc_in;
                  mcand_ff  <= DVW'(RPM_Q4_SCALE);
                  mplier_ff <= ratio_ff;
                  acc_ff    <= '0;
                  step_ff   <= CW'(MUL_BITS);
                  state_ff  <= S_MUL_NUM;
               end else begin
                  acc_ff    <= acc_in;
                  mcand_ff  <= mcand_ff << 1;
                  mplier_ff <= mplier_ff >> 1;
                  step_ff   <= step_ff - CW'(1);
               end
            end
            S_MUL_NUM: begin
               if (last_in) begin
                  quo_ff   <= QW'(acc_in[NUM_BITS-1:0]) << (QW - NUM_BITS);
                  rem_ff   <= '0;
                  step_ff  <= CW'(NUM_BITS);
                  state_ff <= S_DIV_RPM;
               end else begin
                  acc_ff    <= acc_in;
                  mcand_ff  <= mcand_ff << 1;
                  mplier_ff <= mplier_ff >> 1;
                  step_ff   <= step_ff - CW'(1);
               end
            end
            S_DIV_RPM: begin
               quo_ff  <= quo_in;
               rem_ff  <= rem_in;
               step_ff <= step_ff - CW'(1);
               if (last_in) begin
                  if (quo_in > QW'(RPM_MAX)) begin
                     fresh_ff <= RPM_MAX;
                     sat_ff   <= 1'b1;
                  end else begin
                     fresh_ff <= quo_in[RPM_BITS-1:0];
                  end
                  state_ff <= S_SMOOTH;
               end
            end
            S_SMOOTH: begin
               upd_ff <= 1'b1;
               if ((s_in != '0) && !rapid_in && (smooth_ff != '0)) begin
                  quo_ff   <= QW'(wsum_in) << (QW - WSUM_BITS);
                  rem_ff   <= '0;
                  dvs_ff   <= DVW'(STRENGTH_FULL);
                  step_ff  <= CW'(WSUM_BITS);
                  state_ff <= S_DIV_EMA;
               end else begin
                  shown_ff  <= fresh_ff;
                  smooth_ff <= fresh_ff;
                  state_ff  <= S_FINISH;
               end
            end
            S_DIV_EMA: begin
               quo_ff  <= quo_in;
               rem_ff  <= rem_in;
               step_ff <= step_ff - CW'(1);
               if (last_in) begin
                  shown_ff  <= quo_in[RPM_BITS-1:0];
                  smooth_ff <= quo_in[RPM_BITS-1:0];
                  state_ff  <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff.rpm_q4    <= shown_ff;
                  rsp_data_ff.updated   <= upd_ff;
                  rsp_data_ff.timed_out <= tmo_ff;
                  rsp_data_ff.saturated <= sat_ff;
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: sv/ptrf_checker.sv
module ptrf_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ptrf_pkg::rsp_word_type rsp_data
);
   import ptrf_pkg::*;

   // timeout result always shows zero speed
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.timed_out |-> rsp_data.rpm_q4 == '0)
      else $error("timed out word with nonzero speed");

   a_upd_tmo_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.updated |-> !rsp_data.timed_out)
      else $error("word both updated and timed out");

   a_sat_upd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> rsp_data.updated)
      else $error("saturated without update");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

endmodule

bind pulse_tachometer_rpm_filter ptrf_checker u_ptrf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: test/rpm_checker.sv
module rpm_checker #(
   parameter int SUM_BITS = 40
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  ptrf_pkg::req_word_type              req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  ptrf_pkg::rsp_word_type              rsp_data,
   input  logic                                csr_we,
   input  logic [ptrf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ptrf_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  failures,
   output int                                  pending
);
   import ptrf_pkg::*;

   localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_BITS) - 64'd1;

   logic [MUL_BITS-1:0]      ppr_reg;
   logic [MUL_BITS-1:0]      ratio_reg;
   logic [STRENGTH_BITS-1:0] strength_reg;
   logic [TIMEOUT_BITS-1:0]  timeout_reg;

   logic [TIME_BITS-1:0]     last_pulse_us;
   logic                     pulse_seen;
   logic [63:0]              period_sum;
   logic [COUNT_BITS-1:0]    period_count;
   logic [RPM_BITS-1:0]      shown_q4;
   logic [RPM_BITS-1:0]      smoothed_q4;

   rsp_word_type             readings[$];

   function automatic rsp_word_type next_reading(req_word_type w);
      rsp_word_type            r;
      logic [TIME_BITS-1:0]    gap;
      logic [63:0]             avg;
      logic [63:0]             fresh;
      logic [63:0]             mult;
      logic [63:0]             blend;
      logic [STRENGTH_BITS-1:0] s;
      logic                    rapid;
      r = '0;
      gap = w.time_us - last_pulse_us;
      if (w.op == OP_PULSE) begin
         if (pulse_seen) begin
            if (period_sum > SUM_LIMIT - 64'(gap))
               period_sum = SUM_LIMIT;
            else
               period_sum = period_sum + 64'(gap);
            if (period_count < COUNT_MAX)
               period_count = period_count + COUNT_BITS'(1);
         end
         last_pulse_us = w.time_us;
         pulse_seen = 1'b1;
      end else if (!pulse_seen || gap > TIME_BITS'(timeout_reg)) begin
         shown_q4 = '0;
         smoothed_q4 = '0;
         period_sum = '0;
         period_count = '0;
         r.timed_out = 1'b1;
      end else if (period_count != '0) begin
         avg = period_sum / 64'(period_count);
         if (avg != '0) begin
            mult = (ppr_reg == '0) ? 64'd1 : 64'(ppr_reg);
            fresh = (64'(RPM_Q4_SCALE) * 64'(ratio_reg)) / (avg * mult);
            s = (strength_reg > STRENGTH_FULL) ? STRENGTH_FULL : strength_reg;
            if (fresh > 64'(RPM_MAX)) begin
               fresh = 64'(RPM_MAX);
               r.saturated = 1'b1;
            end
            // sharp slowdown skips the filter
            rapid = (shown_q4 > DECEL_FLOOR_Q4) && (fresh * 64'd10 < 64'(shown_q4) * 64'd7);
            if (s != '0 && !rapid) begin
               if (smoothed_q4 == '0) begin
                  smoothed_q4 = RPM_BITS'(fresh);
               end else begin
                  blend = 64'(smoothed_q4) * 64'(s)
                        + fresh * (64'(STRENGTH_FULL) - 64'(s)) + 64'(EMA_ROUND);
                  smoothed_q4 = RPM_BITS'(blend / 64'd10);
               end
               shown_q4 = smoothed_q4;
            end else begin
               shown_q4 = RPM_BITS'(fresh);
               smoothed_q4 = RPM_BITS'(fresh);
            end
            r.updated = 1'b1;
         end
         period_sum = '0;
         period_count = '0;
      end
      r.rpm_q4 = shown_q4;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         ppr_reg = PPR_RESET;
         ratio_reg = RATIO_RESET;
         strength_reg = STRENGTH_RESET;
         timeout_reg = TIMEOUT_RESET;
         last_pulse_us = '0;
         pulse_seen = 1'b0;
         period_sum = '0;
         period_count = '0;
         shown_q4 = '0;
         smoothed_q4 = '0;
         readings.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_PPR:      ppr_reg = csr_wdata[MUL_BITS-1:0];
               CSR_RATIO:    ratio_reg = csr_wdata[MUL_BITS-1:0];
               CSR_STRENGTH: strength_reg = csr_wdata[STRENGTH_BITS-1:0];
               CSR_TIMEOUT:  timeout_reg = csr_wdata[TIMEOUT_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            readings.push_back(next_reading(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (readings.size() == 0) begin
               failures++;
               $display("%0t: expected no word, got %p", $time, rsp_data);
            end else begin
               want = readings.pop_front();
               check_field("rpm_q4", 32'(want.rpm_q4), 32'(rsp_data.rpm_q4));
               check_field("updated", 32'(want.updated), 32'(rsp_data.updated));
               check_field("timed_out", 32'(want.timed_out), 32'(rsp_data.timed_out));
               check_field("saturated", 32'(want.saturated), 32'(rsp_data.saturated));
            end
         end
      end
      pending = readings.size();
   end

endmodule

// File: test/testbench.sv
module testbench;
   import ptrf_pkg::*;

   localparam int SUM_BITS    = 40;
   localparam int WORD_TARGET = 1100;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   req_word_type              req_data = '0;
   logic                      req_stall;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_word_type              rsp_data;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int                        failures;
   int                        pending;
   int                        sent = 0;
   logic                      calm = 1'b0;
   logic [31:0]               now_us = '0;
   logic [31:0]               span_us = 32'd1000;
   logic [31:0]               timeout_cfg = 32'(TIMEOUT_RESET);

   always #2 clock = ~clock;

   always @(negedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 22);

   pulse_tachometer_rpm_filter #(
      .SUM_BITS (SUM_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rpm_checker #(
      .SUM_BITS (SUM_BITS)
   ) u_rpm_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   task automatic send_word(op_type op, logic [31:0] t);
      req_word_type w;
      w.op = op;
      w.time_us = t;
      while (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic pulse_at(logic [31:0] t);
      send_word(OP_PULSE, t);
      now_us = t;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
   endtask

   // upper data bits are junk; only the register's own width counts
   task automatic configure(logic [6:0] ppr, logic [6:0] ratio, logic [3:0] strength,
                            logic [23:0] timeout);
      logic [23:0] junk;
      drain();
      junk = 24'($urandom());
      write_reg(CSR_PPR, {junk[23:7], ppr});
      junk = 24'($urandom());
      write_reg(CSR_RATIO, {junk[23:7], ratio});
      junk = 24'($urandom());
      write_reg(CSR_STRENGTH, {junk[23:4], strength});
      write_reg(CSR_TIMEOUT, timeout);
      csr_we <= 1'b0;
      timeout_cfg = 32'(timeout);
   endtask

   function automatic logic [31:0] pick_span();
      case ($urandom_range(9))
         0:       return $urandom_range(3);
         1:       return $urandom_range(1, 20);
         2, 3:    return $urandom_range(20, 2000);
         8:       return $urandom_range(200000, 20000000);
         default: return $urandom_range(2000, 200000);
      endcase
   endfunction

   task automatic spin_episode;
      logic [31:0] step;
      logic [31:0] lim;
      logic [31:0] delay;
      int          n;
      case ($urandom_range(9))
         0, 1, 2: span_us = pick_span();
         3, 4:    span_us = span_us * $urandom_range(10, 20) / 10;
         5, 6:    span_us = span_us * $urandom_range(5, 10) / 10;
         default: ;
      endcase
      if (span_us > 32'd50000000)
         span_us = pick_span();
      if (span_us > timeout_cfg && $urandom_range(3) != 0)
         span_us = $urandom_range(1, timeout_cfg);
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         step = span_us - span_us / 16 + $urandom_range(0, span_us / 8);
         pulse_at(now_us + step);
      end
      lim = (timeout_cfg < span_us) ? timeout_cfg : span_us;
      case ($urandom_range(19))
         0:       delay = timeout_cfg;
         1:       delay = timeout_cfg + 1;
         2:       delay = timeout_cfg + $urandom_range(2, 5000000);
         default: delay = $urandom_range(0, lim);
      endcase
      send_word(OP_EVAL, now_us + delay);
      if ($urandom_range(9) == 0)
         send_word(OP_EVAL, now_us + delay);
   endtask

   task automatic noise_episode;
      logic [31:0] t;
      op_type      op;
      int          n;
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
         op = op_type'($urandom_range(1));
         t = ($urandom_range(1) == 0) ? $urandom() : now_us + $urandom_range(0, 3000);
         if (op == OP_PULSE)
            pulse_at(t);
         else
            send_word(OP_EVAL, t);
      end
   endtask

   initial begin
      int phase_end;
      int phase;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: ppr 1, ratio 1.0, strength 3, timeout 500 ms
      send_word(OP_EVAL, 32'd0);
      pulse_at(32'd1000);
      send_word(OP_EVAL, 32'd1200);
      pulse_at(32'd1000);
      send_word(OP_EVAL, 32'd1000);
      pulse_at(32'd1001);
      send_word(OP_EVAL, 32'd1001);
      pulse_at(32'd61001);
      send_word(OP_EVAL, 32'd61001);
      pulse_at(32'd111001);
      send_word(OP_EVAL, 32'd111001);
      pulse_at(32'd161001);
      pulse_at(32'd211001);
      send_word(OP_EVAL, 32'd211001);
      send_word(OP_EVAL, 32'd711001);
      send_word(OP_EVAL, 32'd711002);
      pulse_at(32'hFFFF_FF00);
      pulse_at(32'h0000_0100);
      send_word(OP_EVAL, 32'h0000_0150);
      pulse_at(32'hFFFF_FFFF);
      send_word(OP_EVAL, 32'hFFFF_FFF0);
      pulse_at(32'd0);
      send_word(OP_EVAL, 32'd0);

      phase = 0;
      while (sent < WORD_TARGET) begin
         case (phase)
            0:       configure(7'd0, 7'd127, 4'd15, 24'hFFFFFF);
            1:       configure(7'd127, 7'd0, 4'd0, 24'd1000);
            2:       configure(7'd66, 7'd100, 4'd10, 24'd10000000);
            3:       configure(7'd1, 7'd1, 4'd11, 24'd0);
            4: begin
               // long pulse train near the wrap: sum and count both saturate
               configure(7'($urandom_range(1, 66)), 7'($urandom_range(1, 100)),
                         4'($urandom_range(0, 10)), 24'hFFFFFF);
               calm = 1'b1;
               for (int i = 0; i < 270; i++)
                  pulse_at(now_us + $urandom_range(32'hFF00_0000, 32'hFFFF_FFFF));
               send_word(OP_EVAL, now_us + $urandom_range(0, 1000));
               send_word(OP_EVAL, now_us + $urandom_range(0, 1000));
               calm = 1'b0;
            end
            default: configure(
                  7'(($urandom_range(1) != 0) ? $urandom_range(1, 66) : $urandom_range(127)),
                  7'(($urandom_range(1) != 0) ? $urandom_range(1, 100) : $urandom_range(127)),
                  4'($urandom_range(15)),
                  24'(($urandom_range(1) != 0) ? $urandom_range(1000, 10000000)
                                               : $urandom_range(24'hFFFFFF)));
         endcase
         if ($urandom_range(2) == 0)
            now_us = 32'hFFFF_FFFF - $urandom_range(0, 100000);
         else
            now_us = $urandom();
         span_us = pick_span();
         phase_end = sent + $urandom_range(60, 120);
         while (sent < phase_end && sent < WORD_TARGET) begin
            if ($urandom_range(99) < 80)
               spin_episode();
            else
               noise_episode();
         end
         phase++;
      end

      drain();
      repeat (130) @(negedge clock);
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: filelist.f
sv/ptrf_pkg.sv
sv/pulse_tachometer_rpm_filter.sv
sv/ptrf_checker.sv
test/rpm_checker.sv
test/testbench.sv
